// ===== rtl/wvsd_pkg.sv =====
// Shared constants for the windowed variance silence detector.
`default_nettype none
package wvsd_pkg;

	// Default parameter values
	localparam int COUNT_BITS_DEF  = 20;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed register widths
	localparam int TICK_W = 16;
	localparam int MIN_W  = 20;
	localparam int THR_W  = 15;
	localparam int CFG_W  = 20;
	localparam int IDX_W  = 2;

	// Digit width of the shared multiply-accumulate unit
	localparam int DIGIT_W = 8;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_ENABLE       = 2'd0;
	localparam logic [IDX_W-1:0] REG_WINDOW_TICKS = 2'd1;
	localparam logic [IDX_W-1:0] REG_MIN_SAMPLES  = 2'd2;
	localparam logic [IDX_W-1:0] REG_THRESHOLD    = 2'd3;

	// Register reset values
	localparam logic              ENABLE_RST       = 1'b1;
	localparam logic [TICK_W-1:0] WINDOW_TICKS_RST = 16'd1000;
	localparam logic [MIN_W-1:0]  MIN_SAMPLES_RST  = 20'd1000;
	localparam logic [THR_W-1:0]  THRESHOLD_RST    = 15'd100;

	// Item kinds
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/windowed_variance_silence_detector.sv =====
// Windowed variance silence detector: top level with shared multiply-accumulate sequencer.
//
// Usage: items arrive on the in_valid/in_ready channel, each either an audio sample
// (func 0, signed sample) or a time tick (func 1). Every accepted request yields exactly
// one result on out_valid/out_ready: silent is the current verdict, decided is 1 when
// that item closed a window and updated the verdict.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always taken and
// must only be issued while the block is idle.
// Timing: all products go through one 8-bit-digit multiply-accumulate unit, one digit
// per cycle. A sample is accepted, squared digit by digit into the sum of squares and
// then passed to the output register. A plain tick, a dropped sample or any item while
// disabled goes straight from acceptance to the output register. A tick that evaluates
// a window runs five products back to back (n*sumsq, sum^2, n^2, thr^2, n^2*thr^2);
// each product ends early when its multiplier has leading zero digits. The block takes
// one item at a time; in_ready is low while it works.
// Reset clears the accumulators, tick counter and verdict, and loads the register
// defaults. A stalled receiver holds the result register; the block finishes the next
// item and then waits until the pending result is taken.
`default_nettype none
module windowed_variance_silence_detector #(
	parameter int COUNT_BITS  = wvsd_pkg::COUNT_BITS_DEF,
	parameter int SAMPLE_BITS = wvsd_pkg::SAMPLE_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [wvsd_pkg::IDX_W-1:0]     cfg_index,
	input  wire  [wvsd_pkg::CFG_W-1:0]     cfg_data,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire                            func,
	input  wire  signed [SAMPLE_BITS-1:0]  sample,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic                           silent,
	output logic                           decided
);

	localparam int S    = SAMPLE_BITS;
	localparam int C    = COUNT_BITS;
	localparam int TW   = wvsd_pkg::THR_W;
	localparam int DIG  = wvsd_pkg::DIGIT_W;
	localparam int SMW  = S + C;            // signed sample sum
	localparam int MW   = S + C - 1;        // magnitude of sum
	localparam int SQW  = 2 * S - 1 + C;    // sum of squares
	localparam int LW   = C + SQW;          // n * sumsq
	localparam int SQPW = 2 * MW;           // sum^2
	localparam int LMW  = 2 * C + 2 * TW;   // n^2 * thr^2
	localparam int PW0  = (LW > SQPW) ? LW : SQPW;
	localparam int PW   = (PW0 > LMW) ? PW0 : LMW;
	localparam int AW   = PW + 1;           // signed accumulator
	localparam int BW   = (MW > 2 * TW) ? MW : 2 * TW;
	localparam int CMW  = (C > wvsd_pkg::MIN_W) ? C : wvsd_pkg::MIN_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam logic [2:0] OP_SQS = 3'd0;   // sample square into sumsq
	localparam logic [2:0] OP_LHS = 3'd1;   // n * sumsq
	localparam logic [2:0] OP_SQ  = 3'd2;   // subtract sum^2
	localparam logic [2:0] OP_NN  = 3'd3;   // n * n
	localparam logic [2:0] OP_T2  = 3'd4;   // thr * thr
	localparam logic [2:0] OP_LIM = 3'd5;   // n^2 * thr^2

	// Configuration registers
	logic                        enable_q;
	logic [wvsd_pkg::TICK_W-1:0] window_ticks_q;
	logic [wvsd_pkg::MIN_W-1:0]  min_samples_q;
	logic [TW-1:0]               threshold_q;

	// Statistics state
	logic signed [SMW-1:0]       sum_q;
	logic [SQW-1:0]              sqsum_q;
	logic [C-1:0]                count_q;
	logic [wvsd_pkg::TICK_W-1:0] ticks_q;
	logic                        silent_flag_q;

	// Sequencer and shared unit
	logic [1:0]    state_q;
	logic [2:0]    op_q;
	logic          sub_q;
	logic [AW-1:0] acc_q;
	logic [AW-1:0] mcand_q;
	logic [BW-1:0] mult_q;
	logic [AW-1:0] diff_q;
	logic [2*C-1:0] nn_q;
	logic          dec_q;

	// Output register
	logic out_valid_q;
	logic out_silent_q;
	logic out_decided_q;

	logic [AW+DIG-1:0]  prod_full;
	logic [AW-1:0]      pp;
	logic [AW-1:0]      acc_nx;
	logic               last_digit;
	logic [S-1:0]       smag;
	logic signed [SMW-1:0] sum_nx;
	logic [SMW-1:0]     sum_neg;
	logic [MW-1:0]      sum_mag;
	logic [wvsd_pkg::TICK_W-1:0] ticks_inc;
	logic               count_full;
	logic               enough;
	logic               in_take;
	logic               out_take;
	logic               fin_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_take   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign silent    = out_silent_q;
	assign decided   = out_decided_q;
	assign out_take  = out_valid_q && out_ready;
	assign fin_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// Shared multiply-accumulate: one multiplier digit per cycle
	assign prod_full  = {{DIG{1'b0}}, mcand_q} * {{AW{1'b0}}, mult_q[DIG-1:0]};
	assign pp         = prod_full[AW-1:0];
	assign acc_nx     = sub_q ? (acc_q - pp) : (acc_q + pp);
	assign last_digit = ((mult_q >> DIG) == '0);

	assign smag       = sample[S-1] ? (~sample + 1'b1) : sample;
	assign sum_nx     = sum_q + SMW'(sample);
	assign sum_neg    = ~sum_q + 1'b1;
	assign sum_mag    = sum_q[SMW-1] ? sum_neg[MW-1:0] : sum_q[MW-1:0];
	assign ticks_inc  = (ticks_q == '1) ? ticks_q : (ticks_q + 1'b1);
	assign count_full = (count_q == '1);
	assign enough     = (CMW'(count_q) >= CMW'(min_samples_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= wvsd_pkg::ENABLE_RST;
			window_ticks_q <= wvsd_pkg::WINDOW_TICKS_RST;
			min_samples_q  <= wvsd_pkg::MIN_SAMPLES_RST;
			threshold_q    <= wvsd_pkg::THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wvsd_pkg::REG_ENABLE:       enable_q       <= cfg_data[0];
				wvsd_pkg::REG_WINDOW_TICKS: window_ticks_q <= cfg_data[wvsd_pkg::TICK_W-1:0];
				wvsd_pkg::REG_MIN_SAMPLES:  min_samples_q  <= cfg_data[wvsd_pkg::MIN_W-1:0];
				wvsd_pkg::REG_THRESHOLD:    threshold_q    <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	// Operand registers of the shared unit carry no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			sub_q <= 1'b0;
			if (func == wvsd_pkg::FUNC_SAMPLE) begin
				acc_q   <= AW'(sqsum_q);
				mcand_q <= AW'(smag);
				mult_q  <= BW'(smag);
			end else begin
				acc_q   <= '0;
				mcand_q <= AW'(sqsum_q);
				mult_q  <= BW'(count_q);
			end
		end else if (state_q == ST_MUL) begin
			if (!last_digit) begin
				acc_q   <= acc_nx;
				mcand_q <= mcand_q << DIG;
				mult_q  <= mult_q >> DIG;
			end else begin
				case (op_q)
					OP_LHS: begin
						// keep n*sumsq, subtract sum^2 from it
						acc_q   <= acc_nx;
						sub_q   <= 1'b1;
						mcand_q <= AW'(sum_mag);
						mult_q  <= BW'(sum_mag);
					end
					OP_SQ: begin
						diff_q  <= acc_nx;
						acc_q   <= '0;
						sub_q   <= 1'b0;
						mcand_q <= AW'(count_q);
						mult_q  <= BW'(count_q);
					end
					OP_NN: begin
						nn_q    <= acc_nx[2*C-1:0];
						acc_q   <= '0;
						mcand_q <= AW'(threshold_q);
						mult_q  <= BW'(threshold_q);
					end
					OP_T2: begin
						acc_q   <= '0;
						mcand_q <= AW'(nn_q);
						mult_q  <= BW'(acc_nx[2*TW-1:0]);
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			op_q          <= OP_SQS;
			dec_q         <= 1'b0;
			sum_q         <= '0;
			sqsum_q       <= '0;
			count_q       <= '0;
			ticks_q       <= '0;
			silent_flag_q <= 1'b0;
			out_valid_q   <= 1'b0;
			out_silent_q  <= 1'b0;
			out_decided_q <= 1'b0;
		end else begin
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						dec_q <= 1'b0;
						if (enable_q && func == wvsd_pkg::FUNC_SAMPLE && !count_full) begin
							sum_q   <= sum_nx;
							count_q <= count_q + 1'b1;
							op_q    <= OP_SQS;
							state_q <= ST_MUL;
						end else if (enable_q && func == wvsd_pkg::FUNC_TICK &&
								ticks_inc >= window_ticks_q) begin
							ticks_q <= '0;
							if (enough) begin
								op_q    <= OP_LHS;
								state_q <= ST_MUL;
							end else begin
								state_q <= ST_FIN;
							end
						end else begin
							// plain tick advances the counter; drop anything else
							if (enable_q && func == wvsd_pkg::FUNC_TICK) begin
								ticks_q <= ticks_inc;
							end
							state_q <= ST_FIN;
						end
					end
				end
				ST_MUL: begin
					if (last_digit) begin
						case (op_q)
							OP_SQS: begin
								sqsum_q <= acc_nx[SQW-1:0];
								state_q <= ST_FIN;
							end
							OP_LHS: op_q <= OP_SQ;
							OP_SQ:  op_q <= OP_NN;
							OP_NN:  op_q <= OP_T2;
							OP_T2:  op_q <= OP_LIM;
							default: begin
								// variance at or below zero, or under threshold squared
								silent_flag_q <= ($signed(diff_q) < $signed(acc_nx)) ||
									(diff_q == '0);
								sum_q   <= '0;
								sqsum_q <= '0;
								count_q <= '0;
								dec_q   <= 1'b1;
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_FIN: begin
					// hold until the result register is free
					if (fin_load) begin
						out_silent_q  <= silent_flag_q;
						out_decided_q <= dec_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_windowed_variance_silence_detector.sv =====
// Self-checking testbench for the windowed variance silence detector.
module tb_windowed_variance_silence_detector;

	// Narrow count to run the block at a size other than its default
	localparam int CNT_BITS   = 12;
	localparam int RAND_ITEMS = 1600;
	localparam int SETTLE     = 40;

	typedef struct packed {
		logic silent;
		logic decided;
	} verdict_t;

	class silence_verdicts;
		bit                          en;
		bit [wvsd_pkg::TICK_W-1:0]   win_ticks;
		bit [wvsd_pkg::MIN_W-1:0]    min_cnt;
		bit [wvsd_pkg::THR_W-1:0]    thr;
		longint                      acc_sum;
		bit [63:0]                   acc_sq;
		longint unsigned             count;
		longint unsigned             count_max;
		int unsigned                 ticks;
		bit                          quiet;
		verdict_t                    verdicts_due[$];
		int                          mismatches;

		function new(int count_bits);
			en         = wvsd_pkg::ENABLE_RST;
			win_ticks  = wvsd_pkg::WINDOW_TICKS_RST;
			min_cnt    = wvsd_pkg::MIN_SAMPLES_RST;
			thr        = wvsd_pkg::THRESHOLD_RST;
			acc_sum    = 0;
			acc_sq     = 0;
			count      = 0;
			count_max  = (64'd1 << count_bits) - 1;
			ticks      = 0;
			quiet      = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [wvsd_pkg::IDX_W-1:0] idx,
				logic [wvsd_pkg::CFG_W-1:0] data);
			case (idx)
				wvsd_pkg::REG_ENABLE:       en = data[0];
				wvsd_pkg::REG_WINDOW_TICKS: win_ticks = data[wvsd_pkg::TICK_W-1:0];
				wvsd_pkg::REG_MIN_SAMPLES:  min_cnt = data[wvsd_pkg::MIN_W-1:0];
				wvsd_pkg::REG_THRESHOLD:    thr = data[wvsd_pkg::THR_W-1:0];
				default: ;
			endcase
		endfunction

		// Exact test: n*sumsq - sum^2 < thr^2 * n^2, nonpositive left side is quiet
		function bit window_is_quiet();
			bit [127:0] n, mag, lhs, sq, lim;
			n   = 128'(count);
			mag = (acc_sum < 0) ? 128'(-acc_sum) : 128'(acc_sum);
			lhs = n * 128'(acc_sq);
			sq  = mag * mag;
			lim = n * n * 128'(thr) * 128'(thr);
			if (sq >= lhs)
				return 1'b1;
			return (lhs - sq) < lim;
		endfunction

		function void note_request(logic f, logic signed [15:0] s);
			verdict_t v;
			longint   sv;
			v.decided = 1'b0;
			sv        = s;
			if (en) begin
				if (f == wvsd_pkg::FUNC_SAMPLE) begin
					// drop samples once the count is full
					if (count < count_max) begin
						acc_sum += sv;
						acc_sq  += 64'(sv * sv);
						count++;
					end
				end else begin
					if (ticks < 32'hFFFF)
						ticks++;
					if (ticks >= win_ticks) begin
						ticks = 0;
						if (count >= min_cnt) begin
							quiet     = window_is_quiet();
							acc_sum   = 0;
							acc_sq    = 0;
							count     = 0;
							v.decided = 1'b1;
						end
					end
				end
			end
			v.silent = quiet;
			verdicts_due.push_back(v);
		endfunction

		function void check_verdict(logic silent, logic decided);
			verdict_t want;
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: silent=%0b decided=%0b", silent, decided);
				return;
			end
			want = verdicts_due.pop_front();
			if (want.silent !== silent || want.decided !== decided) begin
				mismatches++;
				if (mismatches <= 10)
					$display("verdict mismatch: expected silent=%0b decided=%0b, got silent=%0b decided=%0b",
						want.silent, want.decided, silent, decided);
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n    = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [wvsd_pkg::IDX_W-1:0]  cfg_index = '0;
	logic [wvsd_pkg::CFG_W-1:0]  cfg_data  = '0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	logic                        func      = wvsd_pkg::FUNC_SAMPLE;
	logic signed [15:0]          sample    = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic                        silent;
	logic                        decided;

	int in_gap_pct    = 32;
	int out_stall_pct = 32;

	silence_verdicts board;

	windowed_variance_silence_detector #(.COUNT_BITS(CNT_BITS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.silent    (silent),
		.decided   (decided)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#150_000_000;
		$display("windowed_variance_silence_detector verification failed");
		$finish;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_verdict(silent, decided);
	end

	// Call on a falling edge; returns on the falling edge after acceptance with valid held
	task automatic send_request(input logic f, input logic signed [15:0] s);
		while ($urandom_range(99) < in_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		board.note_request(f, s);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [wvsd_pkg::IDX_W-1:0] idx,
			input logic [wvsd_pkg::CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, data);
		@(negedge clk);
	endtask

	// junk fills the bits above each register's width
	task automatic configure(input logic en, input logic [15:0] wt, input logic [19:0] ms,
			input logic [14:0] th, input logic [19:0] junk);
		write_reg(wvsd_pkg::REG_ENABLE, {junk[19:1], en});
		write_reg(wvsd_pkg::REG_WINDOW_TICKS, {junk[19:16], wt});
		write_reg(wvsd_pkg::REG_MIN_SAMPLES, ms);
		write_reg(wvsd_pkg::REG_THRESHOLD, {junk[19:15], th});
		cfg_valid <= 1'b0;
	endtask

	// Hold off until every expected verdict is in, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (board.verdicts_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		int          counted;
		int          phase_no;
		int          phase_len;
		int          tick_pct;
		int          pick;
		int          kind;
		int          dc;
		int          amp;
		int          value;
		logic        en;
		logic [15:0] wt;
		logic [19:0] ms;
		logic [14:0] th;

		board    = new(CNT_BITS);
		counted  = 0;
		phase_no = 0;
		kind     = 0;
		dc       = 0;
		amp      = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register defaults: long window, nothing decides yet
		send_request(wvsd_pkg::FUNC_SAMPLE, -16'sd32768);
		send_request(wvsd_pkg::FUNC_SAMPLE, 16'sd32767);
		send_request(wvsd_pkg::FUNC_SAMPLE, 16'sd0);
		send_request(wvsd_pkg::FUNC_TICK, 16'($urandom));
		send_request(wvsd_pkg::FUNC_SAMPLE, -16'sd1);
		send_request(wvsd_pkg::FUNC_TICK, 16'($urandom));
		drain();

		// zero threshold: short window first, then constant DC and a varying window
		configure(1'b1, 16'd1, 20'd1, 15'd0, '0);
		send_request(wvsd_pkg::FUNC_TICK, 16'($urandom));
		repeat (3) send_request(wvsd_pkg::FUNC_SAMPLE, 16'sd5);
		send_request(wvsd_pkg::FUNC_TICK, 16'($urandom));
		send_request(wvsd_pkg::FUNC_SAMPLE, 16'sd1);
		send_request(wvsd_pkg::FUNC_SAMPLE, 16'sd2);
		send_request(wvsd_pkg::FUNC_TICK, 16'($urandom));
		drain();

		// zero window and zero minimum: empty window, then full-swing and quiet windows
		configure(1'b1, 16'd0, 20'd0, 15'h7FFF, '0);
		send_request(wvsd_pkg::FUNC_TICK, 16'($urandom));
		repeat (2) begin
			send_request(wvsd_pkg::FUNC_SAMPLE, -16'sd32768);
			send_request(wvsd_pkg::FUNC_SAMPLE, 16'sd32767);
		end
		send_request(wvsd_pkg::FUNC_TICK, 16'($urandom));
		send_request(wvsd_pkg::FUNC_SAMPLE, 16'sd100);
		send_request(wvsd_pkg::FUNC_SAMPLE, -16'sd100);
		send_request(wvsd_pkg::FUNC_TICK, 16'($urandom));
		drain();

		// disabled: verdict holds, nothing accumulates
		configure(1'b0, 16'd2, 20'd1, 15'd100, '0);
		send_request(wvsd_pkg::FUNC_SAMPLE, 16'sd7);
		send_request(wvsd_pkg::FUNC_TICK, 16'($urandom));
		send_request(wvsd_pkg::FUNC_TICK, 16'($urandom));
		drain();

		while (counted < RAND_ITEMS) begin
			// the third phase runs enabled and without any idling
			en   = (phase_no == 2) || ($urandom_range(9) != 0);
			pick = $urandom_range(19);
			wt   = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(1, 6));
			pick = $urandom_range(19);
			ms   = (pick == 0) ? 20'hFFFFF : (pick < 4) ? 20'd0 : 20'($urandom_range(1, 12));
			pick = $urandom_range(9);
			th   = (pick == 0) ? 15'd0 : (pick == 1) ? 15'h7FFF : 15'($urandom_range(1, 3000));
			phase_len = (phase_no == 2) ? 300 :
				en ? $urandom_range(120, 250) : $urandom_range(15, 30);
			tick_pct  = $urandom_range(5, 40);
			in_gap_pct    = (phase_no == 2) ? 0 : 32;
			out_stall_pct = (phase_no == 2) ? 0 : 32;
			configure(en, wt, ms, th, 20'($urandom));
			for (int i = 0; i < phase_len; i++) begin
				if ($urandom_range(99) < tick_pct) begin
					send_request(wvsd_pkg::FUNC_TICK, 16'($urandom));
					// switch signal character now and then at a tick
					if ($urandom_range(4) == 0) begin
						kind = $urandom_range(2);
						dc   = int'($urandom_range(65535)) - 32768;
						amp  = (int'(th) * int'($urandom_range(120, 230))) / 100 + 1;
					end
				end else begin
					case (kind)
						0:       value = dc;
						1:       value = dc + int'($urandom_range(0, 2 * amp)) - amp;
						default: value = int'($urandom_range(65535)) - 32768;
					endcase
					if ($urandom_range(9) == 0)
						value = int'($urandom_range(65535)) - 32768;
					if (value > 32767)
						value = 32767;
					if (value < -32768)
						value = -32768;
					send_request(wvsd_pkg::FUNC_SAMPLE, 16'(value));
				end
			end
			counted += phase_len;
			drain();
			phase_no++;
		end

		if (board.mismatches == 0 && board.verdicts_due.size() == 0)
			$display("windowed_variance_silence_detector verification clean");
		else
			$display("windowed_variance_silence_detector verification failed");
		$finish;
	end

endmodule
